/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Same-cycle and next-cycle implication checks, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ELS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ELS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ELS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define ELS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/els_pkg.sv */
// ----------------------------------------------------------------------------
// els_pkg
// Shared constants, codes and types of the LOOK elevator scheduler.
// ----------------------------------------------------------------------------
package els_pkg;

  localparam int FLOOR_COUNT = 16;
  localparam int FLOOR_W     = 4;
  localparam int ID_W        = 7;
  localparam int TYPE_W      = 3;
  localparam int KIND_W      = 2;
  localparam int PEND_W      = 5;
  localparam int PEND_MAX    = 31;
  localparam int IDX_W       = $clog2(FLOOR_COUNT);
  localparam int CNT_W       = $clog2(FLOOR_COUNT + 1);

  localparam logic [TYPE_W-1:0] REQ_INTERNAL  = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_EXTERNAL  = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_ARRIVED   = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_NEW_FLOOR = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_BRAKE     = 3'd4;
  localparam logic [TYPE_W-1:0] REQ_OPEN      = 3'd5;
  localparam logic [TYPE_W-1:0] REQ_TICK      = 3'd6;

  localparam logic [KIND_W-1:0] KIND_TARGET = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DOORS  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic               target_valid;
    logic [FLOOR_W-1:0] target_floor;
    logic               status_direction;
    logic [FLOOR_W-1:0] status_floor;
    logic [PEND_W-1:0]  status_pending;
    logic               status_braked;
  } result_t;

  typedef struct packed {
    logic above;
    logic below;
  } cmp_res_t;

endpackage

/* src/els_cmp_unit.sv */
// ----------------------------------------------------------------------------
// els_cmp_unit
// Shared floor compare unit: places one marked floor above or below the car.
// ----------------------------------------------------------------------------
module els_cmp_unit (
  input  logic                    mark,
  input  logic [els_pkg::IDX_W-1:0] idx,
  input  logic [els_pkg::IDX_W-1:0] cur,
  output els_pkg::cmp_res_t       res
);
  import els_pkg::*;

  assign res.above = mark && (idx > cur);
  assign res.below = mark && (idx < cur);

endmodule

/* src/els_seq.sv */
// ----------------------------------------------------------------------------
// els_seq
// Request sequencer: decodes events, scans floors for counts, then for head.
// ----------------------------------------------------------------------------
module els_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [els_pkg::TYPE_W-1:0] req_type,
  input  logic [els_pkg::FLOOR_W-1:0] floor,
  input  logic [els_pkg::ID_W-1:0]   target_elevator,
  input  logic [els_pkg::ID_W-1:0]   elevator_id,
  output logic                       busy,
  output logic                       res_valid,
  output els_pkg::result_t           res
);
  import els_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_COUNT = 3'b010,
    ST_HEAD  = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [FLOOR_COUNT-1:0] marks_r, marks_nxt;
  logic [IDX_W-1:0]       cur_r, cur_nxt;
  logic                   up_r, up_nxt;
  logic [PEND_W-1:0]      pend_r, pend_nxt;
  logic                   hv_r, hv_nxt;
  logic [IDX_W-1:0]       head_r, head_nxt;
  logic                   braked_r, braked_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0]       ahead_r, ahead_nxt;
  logic [CNT_W-1:0]       behind_r, behind_nxt;
  logic                   res_valid_r, res_valid_nxt;
  result_t                res_r, res_nxt;

  cmp_res_t         cmp;
  logic [IDX_W-1:0] fl_idx;
  logic             fl_ok;
  logic             ahead_hit, behind_hit, take, last;
  logic [CNT_W-1:0] ahead_sum, behind_sum;
  logic [CNT_W:0]   total;

  els_cmp_unit u_cmp (
    .mark (marks_r[idx_r]),
    .idx  (idx_r),
    .cur  (cur_r),
    .res  (cmp)
  );

  assign fl_idx     = IDX_W'(floor);
  assign fl_ok      = int'(floor) < FLOOR_COUNT;
  assign ahead_hit  = up_r ? cmp.above : cmp.below;
  assign behind_hit = up_r ? cmp.below : cmp.above;
  assign ahead_sum  = ahead_r + CNT_W'(ahead_hit);
  assign behind_sum = behind_r + CNT_W'(behind_hit);
  assign total      = {1'b0, ahead_sum} + {1'b0, behind_sum};
  assign last       = (idx_r == IDX_W'(FLOOR_COUNT - 1));
  assign take       = up_r ? (cmp.above && !hv_r) : cmp.below;

  always_comb begin
    logic [FLOOR_COUNT-1:0] marks_v;
    logic                   reorder;
    marks_v       = marks_r;
    reorder       = 1'b0;
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    up_nxt        = up_r;
    pend_nxt      = pend_r;
    hv_nxt        = hv_r;
    head_nxt      = head_r;
    braked_nxt    = braked_r;
    idx_nxt       = idx_r;
    ahead_nxt     = ahead_r;
    behind_nxt    = behind_r;
    res_valid_nxt = 1'b0;
    res_nxt       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (req_type)
            REQ_INTERNAL: begin
              if (!braked_r && fl_ok) begin
                marks_v[fl_idx] = 1'b1;
                reorder         = 1'b1;
              end
            end
            REQ_EXTERNAL: begin
              if (!braked_r && target_elevator == elevator_id && fl_ok) begin
                if (fl_idx == cur_r && pend_r == '0) begin
                  res_valid_nxt = 1'b1;
                  res_nxt.kind  = KIND_DOORS;
                end else begin
                  marks_v[fl_idx] = 1'b1;
                  reorder         = 1'b1;
                end
              end
            end
            REQ_ARRIVED: begin
              if (hv_r) begin
                marks_v[head_r] = 1'b0;
              end
              reorder = 1'b1;
            end
            REQ_NEW_FLOOR: begin
              if (fl_ok) begin
                cur_nxt = fl_idx;
              end
            end
            REQ_BRAKE: begin
              braked_nxt = 1'b1;
            end
            REQ_OPEN: begin
              res_valid_nxt = 1'b1;
              res_nxt.kind  = KIND_DOORS;
            end
            REQ_TICK: begin
              res_valid_nxt            = 1'b1;
              res_nxt.kind             = KIND_STATUS;
              res_nxt.status_direction = up_r;
              res_nxt.status_floor     = FLOOR_W'(cur_r);
              res_nxt.status_pending   = pend_r;
              res_nxt.status_braked    = braked_r;
            end
            default: begin
            end
          endcase
          if (reorder) begin
            marks_v[cur_r] = 1'b0;
            idx_nxt        = '0;
            ahead_nxt      = '0;
            behind_nxt     = '0;
            state_nxt      = ST_COUNT;
          end
        end
      end
      ST_COUNT: begin
        ahead_nxt  = ahead_sum;
        behind_nxt = behind_sum;
        idx_nxt    = idx_r + 1'b1;
        if (last) begin
          if (ahead_sum == '0 && behind_sum != '0) begin
            up_nxt = !up_r;
          end
          pend_nxt  = (int'(total) > PEND_MAX) ? PEND_W'(PEND_MAX) : PEND_W'(total);
          idx_nxt   = '0;
          hv_nxt    = 1'b0;
          head_nxt  = '0;
          state_nxt = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (take) begin
          hv_nxt   = 1'b1;
          head_nxt = idx_r;
        end
        idx_nxt = idx_r + 1'b1;
        if (last) begin
          res_valid_nxt        = 1'b1;
          res_nxt.kind         = KIND_TARGET;
          res_nxt.target_valid = hv_r || take;
          res_nxt.target_floor = (hv_r || take) ? FLOOR_W'(take ? idx_r : head_r) : '0;
          idx_nxt              = '0;
          state_nxt            = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    marks_nxt = marks_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      marks_r     <= '0;
      cur_r       <= '0;
      up_r        <= 1'b1;
      pend_r      <= '0;
      hv_r        <= 1'b0;
      head_r      <= '0;
      braked_r    <= 1'b0;
      idx_r       <= '0;
      ahead_r     <= '0;
      behind_r    <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      marks_r     <= marks_nxt;
      cur_r       <= cur_nxt;
      up_r        <= up_nxt;
      pend_r      <= pend_nxt;
      hv_r        <= hv_nxt;
      head_r      <= head_nxt;
      braked_r    <= braked_nxt;
      idx_r       <= idx_nxt;
      ahead_r     <= ahead_nxt;
      behind_r    <= behind_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

/* src/elevator_look_scheduler_top.sv */
// ----------------------------------------------------------------------------
// elevator_look_scheduler_top
// LOOK request scheduler for one elevator car, command-style interface.
// ----------------------------------------------------------------------------
// An event is taken when start is high and busy is low. Floor requests and
// arrivals start a reorder that walks every floor twice through one shared
// compare unit, once to count floors ahead and behind, once to find the
// nearest floor ahead: busy stays high through both walks, and the new
// target shows in the cycle where busy falls. Every other event leaves busy
// low, and its result, if any, shows on the next cycle. Each
// result is on the out_ ports for exactly one cycle with out_valid high;
// the receiver cannot stall, so it must take every transfer as it comes.
// Write cfg_wdata with cfg_we only while the block is idle.
`include "assert_macros.svh"

module elevator_look_scheduler_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [els_pkg::TYPE_W-1:0]  in_req_type,
  input  logic [els_pkg::FLOOR_W-1:0] in_floor,
  input  logic [els_pkg::ID_W-1:0]    in_target_elevator,
  input  logic                        cfg_we,
  input  logic [els_pkg::ID_W-1:0]    cfg_wdata,
  output logic                        out_valid,
  output logic [els_pkg::KIND_W-1:0]  out_result_kind,
  output logic                        out_target_valid,
  output logic [els_pkg::FLOOR_W-1:0] out_target_floor,
  output logic                        out_status_direction,
  output logic [els_pkg::FLOOR_W-1:0] out_status_floor,
  output logic [els_pkg::PEND_W-1:0]  out_status_pending,
  output logic                        out_status_braked
);
  import els_pkg::*;

  logic [ID_W-1:0] elevator_id_r, elevator_id_nxt;
  result_t         res;
  logic            tick_take, brake_take, status_out, other_out;

  assign elevator_id_nxt = cfg_we ? cfg_wdata : elevator_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elevator_id_r <= '0;
    end else begin
      elevator_id_r <= elevator_id_nxt;
    end
  end

  els_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .req_type        (in_req_type),
    .floor           (in_floor),
    .target_elevator (in_target_elevator),
    .elevator_id     (elevator_id_r),
    .busy            (busy),
    .res_valid       (out_valid),
    .res             (res)
  );

  assign out_result_kind      = res.kind;
  assign out_target_valid     = res.target_valid;
  assign out_target_floor     = res.target_floor;
  assign out_status_direction = res.status_direction;
  assign out_status_floor     = res.status_floor;
  assign out_status_pending   = res.status_pending;
  assign out_status_braked    = res.status_braked;

  assign tick_take  = start && !busy && (in_req_type == REQ_TICK);
  assign brake_take = start && !busy && (in_req_type == REQ_BRAKE);
  assign status_out = out_valid && (out_result_kind == KIND_STATUS);
  assign other_out  = out_valid && (out_result_kind != KIND_TARGET);

  `ELS_ASSERT_SAME(a_out_when_idle, clk, rst_n, out_valid, !busy, "result while busy")
  `ELS_ASSERT_NEXT(a_tick_status, clk, rst_n, tick_take, status_out, "tick gave no status")
  `ELS_ASSERT_SAME(a_target_only, clk, rst_n, other_out, !out_target_valid, "stray target flag")
  `ELS_ASSERT_NEXT(a_brake_silent, clk, rst_n, brake_take, !out_valid && !busy, "brake result")

endmodule
